@@ rtl/csrf_pkg.sv @@
package csrf_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int QUEUE_DEPTH     = 4;

	localparam int CRD_W      = 16;
	localparam int COLOR_W    = 8;
	localparam int ADDR_W     = 25;
	localparam int LEVEL_W    = 5;
	localparam int FRAME_W    = 13;
	localparam int BASE_W     = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int PROD_W     = CRD_W + FRAME_W;

	localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 13'd320;
	localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 13'd240;
	localparam logic [FRAME_W-1:0] ROW_STRIDE_RST   = 13'd320;
	localparam logic [BASE_W-1:0]  BASE_ADDRESS_RST = 24'd0;

	typedef enum logic [1:0] {
		KIND_FILL = 2'd0,
		KIND_PUSH = 2'd1,
		KIND_POP  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_OUTSIDE   = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_ROW_STRIDE   = 3'd2,
		REG_BASE_ADDRESS = 3'd3,
		REG_CLIP_EN      = 3'd4
	} reg_idx_t;

	typedef enum logic {
		OP_FILL = 1'b0,
		OP_PASS = 1'b1
	} op_t;

	typedef enum logic {
		FR_RUN    = 1'b0,
		FR_REFILL = 1'b1
	} front_state_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] x;
		logic signed [CRD_W-1:0] y;
		logic signed [CRD_W-1:0] w;
		logic signed [CRD_W-1:0] h;
	} rect_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic signed [CRD_W-1:0] pos_x;
		logic signed [CRD_W-1:0] pos_y;
		logic signed [CRD_W-1:0] rect_width;
		logic signed [CRD_W-1:0] rect_height;
		logic [COLOR_W-1:0]      fill_color;
	} cmd_t;

	typedef struct packed {
		logic                    write_enable;
		logic [ADDR_W-1:0]       start_address;
		logic signed [CRD_W-1:0] out_x;
		logic signed [CRD_W-1:0] out_y;
		logic signed [CRD_W-1:0] out_width;
		logic signed [CRD_W-1:0] out_height;
		logic [COLOR_W-1:0]      out_color;
		logic [1:0]              status;
		logic [LEVEL_W-1:0]      stack_level;
	} res_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_width;
		logic [FRAME_W-1:0] frame_height;
		logic [FRAME_W-1:0] row_stride;
		logic [BASE_W-1:0]  base_address;
		logic               clip_en;
	} cfg_t;

	typedef struct packed {
		op_t                op;
		status_t            status;
		logic [LEVEL_W-1:0] level;
		rect_t              rect;
		rect_t              clip;
		logic [COLOR_W-1:0] color;
	} job_t;

endpackage

@@ rtl/csrf_if.sv @@
interface csrf_cmd_if;
	logic              valid;
	logic              ready;
	csrf_pkg::cmd_t    data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface csrf_res_if;
	logic              valid;
	logic              ready;
	csrf_pkg::res_t    data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/csrf_front.sv @@
module csrf_front #(
	parameter int STACK_DEPTH = csrf_pkg::STACK_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	csrf_cmd_if.sink       cmd,
	input  csrf_pkg::cfg_t cfg,
	output logic           job_vld,
	output csrf_pkg::job_t job,
	input  logic           job_rdy
);
	import csrf_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	front_state_t          state_q, state_d;
	logic [CNT_W-1:0]      count_q, count_d, cnt_m1, cnt_m2;
	logic [CNT_W+4:0]      level_ext;
	rect_t                 top_q, rd_q, cmd_rect;
	rect_t                 mem_q [STACK_DEPTH];
	logic                  accept, empty, full, has_below;
	logic                  push_ok, pop_ok;

	assign accept    = cmd.valid && cmd.ready;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(STACK_DEPTH));
	assign has_below = ({1'b0, count_q} > (CNT_W+1)'(1));
	assign push_ok   = accept && (cmd.data.kind == KIND_PUSH) && !full;
	assign pop_ok    = accept && (cmd.data.kind == KIND_POP) && !empty;
	assign cnt_m1    = count_q - CNT_W'(1);
	assign cnt_m2    = count_q - CNT_W'(2);

	assign cmd_rect.x = cmd.data.pos_x;
	assign cmd_rect.y = cmd.data.pos_y;
	assign cmd_rect.w = cmd.data.rect_width;
	assign cmd_rect.h = cmd.data.rect_height;

	always_comb begin
		count_d = count_q;
		if (push_ok) begin
			count_d = count_q + CNT_W'(1);
		end else if (pop_ok) begin
			count_d = cnt_m1;
		end
	end

	assign level_ext = (CNT_W+5)'(count_d);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_RUN: begin
				if (pop_ok && has_below) begin
					state_d = FR_REFILL;
				end
			end
			FR_REFILL: state_d = FR_RUN;
			default:   state_d = FR_RUN;
		endcase
	end

	// outputs
	always_comb begin
		cmd.ready = (state_q == FR_RUN) && job_rdy;
		job_vld   = accept;
		job.op     = OP_PASS;
		job.status = ST_OK;
		job.level  = level_ext[LEVEL_W-1:0];
		job.rect   = '0;
		job.clip   = top_q;
		job.color  = '0;
		case (cmd.data.kind)
			KIND_FILL: begin
				job.op    = OP_FILL;
				job.rect  = cmd_rect;
				job.color = cmd.data.fill_color;
				if (empty) begin
					job.clip.x = '0;
					job.clip.y = '0;
					job.clip.w = CRD_W'(cfg.frame_width);
					job.clip.h = CRD_W'(cfg.frame_height);
				end
			end
			KIND_PUSH: begin
				if (full) begin
					job.status = ST_OVERFLOW;
				end
			end
			KIND_POP: begin
				if (empty) begin
					job.status = ST_UNDERFLOW;
				end else begin
					job.rect = top_q;
				end
			end
			default: job.op = OP_PASS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_RUN;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// top of stack in flops, the rest in memory
	always_ff @(posedge clk) begin
		if (push_ok) begin
			top_q <= cmd_rect;
		end else if (state_q == FR_REFILL) begin
			top_q <= rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok && !empty) begin
			mem_q[cnt_m1[IDX_W-1:0]] <= top_q;
		end
		if (pop_ok) begin
			rd_q <= mem_q[cnt_m2[IDX_W-1:0]];
		end
	end

endmodule

@@ rtl/csrf_queue.sv @@
module csrf_queue #(
	parameter int DEPTH = csrf_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  csrf_pkg::job_t in_data,
	output logic           in_rdy,
	output logic           out_vld,
	output csrf_pkg::job_t out_data,
	input  logic           out_rdy
);
	import csrf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             buf_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             wr, rd;

	assign in_rdy   = (fill_q != CNT_W'(DEPTH));
	assign out_vld  = (fill_q != '0);
	assign out_data = buf_q[rd_ptr_q];
	assign wr       = in_vld && in_rdy;
	assign rd       = out_vld && out_rdy;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (rd) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (wr && !rd) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (rd && !wr) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			buf_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

@@ rtl/csrf_back.sv @@
module csrf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_vld,
	input  csrf_pkg::job_t job,
	output logic           job_rdy,
	input  csrf_pkg::cfg_t cfg,
	csrf_res_if.source     res
);
	import csrf_pkg::*;

	localparam int SUM_W = CRD_W + 1;
	localparam int DIF_W = CRD_W + 2;
	localparam int END_W = CRD_W + 3;

	logic                    en;
	logic                    res_vld_q;
	res_t                    res_q;

	// stage 1: intersection
	logic                    vld_s1, fill_s1;
	status_t                 status_s1;
	logic [LEVEL_W-1:0]      level_s1;
	logic [COLOR_W-1:0]      color_s1;
	logic signed [CRD_W-1:0] x0_s1, y0_s1;
	logic signed [DIF_W-1:0] w_s1, h_s1;

	logic signed [SUM_W-1:0] ax1, ay1, cx1, cy1, x1, y1;
	logic signed [CRD_W-1:0] x0, y0;
	logic signed [DIF_W-1:0] wd, hd;

	// stage 2: frame check and row multiply
	logic                    vld_s2, we_s2;
	status_t                 status_s2;
	logic [LEVEL_W-1:0]      level_s2;
	logic [COLOR_W-1:0]      color_s2;
	rect_t                   reg_s2;
	logic [PROD_W-1:0]       prod_s2;

	logic                    nonempty, outside;
	logic signed [END_W-1:0] xe, ye;
	logic [ADDR_W-1:0]       addr;
	rect_t                   reg_d;
	logic                    we_d;
	status_t                 status_d;

	assign en      = !res_vld_q || res.ready;
	assign job_rdy = en;

	always_comb begin
		ax1 = SUM_W'(job.rect.x) + SUM_W'(job.rect.w);
		ay1 = SUM_W'(job.rect.y) + SUM_W'(job.rect.h);
		cx1 = SUM_W'(job.clip.x) + SUM_W'(job.clip.w);
		cy1 = SUM_W'(job.clip.y) + SUM_W'(job.clip.h);
		x0  = (job.rect.x > job.clip.x) ? job.rect.x : job.clip.x;
		y0  = (job.rect.y > job.clip.y) ? job.rect.y : job.clip.y;
		x1  = (ax1 < cx1) ? ax1 : cx1;
		y1  = (ay1 < cy1) ? ay1 : cy1;
		wd  = DIF_W'(x1) - DIF_W'(x0);
		hd  = DIF_W'(y1) - DIF_W'(y0);
		if (!(cfg.clip_en && (job.op == OP_FILL))) begin
			x0 = job.rect.x;
			y0 = job.rect.y;
			wd = DIF_W'(job.rect.w);
			hd = DIF_W'(job.rect.h);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			res_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= job_vld;
			vld_s2    <= vld_s1;
			res_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fill_s1   <= (job.op == OP_FILL);
			status_s1 <= job.status;
			level_s1  <= job.level;
			color_s1  <= job.color;
			x0_s1     <= x0;
			y0_s1     <= y0;
			w_s1      <= wd;
			h_s1      <= hd;
		end
	end

	always_comb begin
		nonempty = (w_s1 > DIF_W'(0)) && (h_s1 > DIF_W'(0));
		xe       = END_W'(x0_s1) + END_W'(w_s1);
		ye       = END_W'(y0_s1) + END_W'(h_s1);
		outside  = x0_s1[CRD_W-1] || y0_s1[CRD_W-1] ||
			(xe > $signed(END_W'(cfg.frame_width))) ||
			(ye > $signed(END_W'(cfg.frame_height)));
		reg_d.x  = x0_s1;
		reg_d.y  = y0_s1;
		reg_d.w  = w_s1[CRD_W-1:0];
		reg_d.h  = h_s1[CRD_W-1:0];
		we_d     = 1'b0;
		status_d = status_s1;
		if (fill_s1) begin
			if (nonempty) begin
				we_d     = !outside;
				status_d = outside ? ST_OUTSIDE : ST_OK;
			end else begin
				reg_d    = '0;
				status_d = ST_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			level_s2  <= level_s1;
			color_s2  <= fill_s1 ? color_s1 : '0;
			prod_s2   <= PROD_W'(y0_s1[CRD_W-1:0]) * PROD_W'(cfg.row_stride);
			reg_s2    <= reg_d;
			we_s2     <= we_d;
			status_s2 <= status_d;
		end
	end

	assign addr = ADDR_W'(cfg.base_address) + prod_s2[ADDR_W-1:0] +
		ADDR_W'(reg_s2.x[CRD_W-1:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.write_enable  <= we_s2;
			res_q.start_address <= we_s2 ? addr : '0;
			res_q.out_x         <= reg_s2.x;
			res_q.out_y         <= reg_s2.y;
			res_q.out_width     <= reg_s2.w;
			res_q.out_height    <= reg_s2.h;
			res_q.out_color     <= color_s2;
			res_q.status        <= status_s2;
			res_q.stack_level   <= level_s2;
		end
	end

	assign res.valid = res_vld_q;
	assign res.data  = res_q;

endmodule

@@ rtl/clip_stack_rect_fill_unit.sv @@
// Clip stack and rectangle fill unit. Takes one request per cycle while the queue has room:
// fills, clip pushes and clip pops. The one exception is a pop that leaves at least one
// rectangle on the stack, which holds off the next request while the rectangle below the
// top comes out of the stack memory through its registered read port. A four-entry queue
// between the stack front end and the clipping back end lets the command side run ahead of
// a stalled result side. Registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the unit is idle, since the unit itself does not enforce it.
module clip_stack_rect_fill_unit #(
	parameter int STACK_DEPTH = csrf_pkg::STACK_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [csrf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [csrf_pkg::CFG_DATA_W-1:0] cfg_data,
	csrf_cmd_if.sink                        cmd,
	csrf_res_if.source                      res
);
	import csrf_pkg::*;

	cfg_t cfg_q;
	job_t front_job, back_job;
	logic front_vld, front_rdy, back_vld, back_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= FRAME_WIDTH_RST;
			cfg_q.frame_height <= FRAME_HEIGHT_RST;
			cfg_q.row_stride   <= ROW_STRIDE_RST;
			cfg_q.base_address <= BASE_ADDRESS_RST;
			cfg_q.clip_en      <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data[FRAME_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[FRAME_W-1:0];
				REG_ROW_STRIDE:   cfg_q.row_stride   <= cfg_data[FRAME_W-1:0];
				REG_BASE_ADDRESS: cfg_q.base_address <= cfg_data[BASE_W-1:0];
				REG_CLIP_EN:      cfg_q.clip_en      <= cfg_data[0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	csrf_front #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.job_vld(front_vld),
		.job    (front_job),
		.job_rdy(front_rdy)
	);

	csrf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (front_vld),
		.in_data (front_job),
		.in_rdy  (front_rdy),
		.out_vld (back_vld),
		.out_data(back_job),
		.out_rdy (back_rdy)
	);

	csrf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.job_vld(back_vld),
		.job    (back_job),
		.job_rdy(back_rdy),
		.cfg    (cfg_q),
		.res    (res)
	);

endmodule

@@ rtl/csrf_checker.sv @@
module csrf_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_ready,
	input csrf_pkg::res_t res_data
);
	import csrf_pkg::*;

	// a written region is always a positive, in-frame span
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.write_enable |->
			res_data.status == ST_OK && !res_data.out_width[CRD_W-1] &&
			res_data.out_width != '0 && !res_data.out_height[CRD_W-1] &&
			res_data.out_height != '0 && !res_data.out_x[CRD_W-1] &&
			!res_data.out_y[CRD_W-1])
		else $error("write request with bad region");

	// stack errors carry no region and no colour
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status == ST_OVERFLOW || res_data.status == ST_UNDERFLOW) |->
			!res_data.write_enable && res_data.start_address == '0 &&
			res_data.out_x == '0 && res_data.out_y == '0 &&
			res_data.out_width == '0 && res_data.out_height == '0 &&
			res_data.out_color == '0)
		else $error("stack error with payload");

	// an empty pop leaves the stack empty
	a_underflow_level: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status == ST_UNDERFLOW |-> res_data.stack_level == '0)
		else $error("underflow with non-zero level");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result dropped while stalled");

endmodule

bind clip_stack_rect_fill_unit csrf_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_data (res.data)
);
